### src/fvcw_pkg.sv
// Package for the flow vector color wheel: pipeline item type, stage map,
// color wheel table and CORDIC arctangent table.
// Used by flow_vector_color_wheel; depends on nothing.
package fvcw_pkg;

  localparam int WHEEL_ENTRIES = 55;
  localparam int TURN_BITS     = 20;
  localparam int CORDIC_STEPS  = 16;
  localparam int SQRT_STEPS    = 32;
  localparam int DIV_STEPS     = 17;

  // Stage map of the pipeline.
  localparam int ST_SQ        = 2;
  localparam int ST_CMP       = 3;
  localparam int CORDIC_FIRST = 2;
  localparam int SQRT_FIRST   = 3;
  localparam int ST_POS       = CORDIC_FIRST + CORDIC_STEPS;
  localparam int ST_LUT       = ST_POS + 1;
  localparam int ST_MIX       = ST_LUT + 1;
  localparam int ST_SAT       = ST_MIX + 1;
  localparam int DIV_FIRST    = SQRT_FIRST + SQRT_STEPS;
  localparam int ST_PROD      = DIV_FIRST + DIV_STEPS;
  localparam int ST_OUT       = ST_PROD + 1;
  localparam int NUM_STAGES   = ST_OUT + 1;

  localparam logic [15:0] MAX_RADIUS_RESET = 16'd2560;

  // Pixel: element 2 is red, 1 is green, 0 is blue.
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic              fv;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]       m;
    logic [30:0]       x2;
    logic [30:0]       y2;
    logic [31:0]       mm;
    logic [31:0]       sq;
    logic              in_circle;
    logic [33:0]       srem;
    logic [31:0]       root;
    logic [16:0]       drem;
    logic [16:0]       quot;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [21:0] cz;
    logic              spec;
    logic [19:0]       sang;
    logic [5:0]        k0;
    logic [19:0]       fr;
    rgb_t              w0;
    rgb_t              w1;
    logic [2:0][27:0]  c;
    logic [2:0][27:0]  d;
    rgb_t              vo;
    logic [2:0][44:0]  prod;
    rgb_t              px;
  } item_t;

  // Arctangent of 2^-i in units of 2^-20 turn.
  localparam logic [17:0] ATAN_TURNS [CORDIC_STEPS] = '{
    18'd131072, 18'd77376, 18'd40884, 18'd20753, 18'd10417, 18'd5213,
    18'd2607, 18'd1304, 18'd652, 18'd326, 18'd163, 18'd81, 18'd41,
    18'd20, 18'd10, 18'd5
  };

  // Color wheel, {red, green, blue} per entry.
  localparam rgb_t WHEEL [WHEEL_ENTRIES] = '{
    {8'd255,8'd0,8'd0},   {8'd255,8'd17,8'd0},  {8'd255,8'd34,8'd0},
    {8'd255,8'd51,8'd0},  {8'd255,8'd68,8'd0},  {8'd255,8'd85,8'd0},
    {8'd255,8'd102,8'd0}, {8'd255,8'd119,8'd0}, {8'd255,8'd136,8'd0},
    {8'd255,8'd153,8'd0}, {8'd255,8'd170,8'd0}, {8'd255,8'd187,8'd0},
    {8'd255,8'd204,8'd0}, {8'd255,8'd221,8'd0}, {8'd255,8'd238,8'd0},
    {8'd255,8'd255,8'd0}, {8'd213,8'd255,8'd0}, {8'd170,8'd255,8'd0},
    {8'd128,8'd255,8'd0}, {8'd85,8'd255,8'd0},  {8'd43,8'd255,8'd0},
    {8'd0,8'd255,8'd0},   {8'd0,8'd255,8'd63},  {8'd0,8'd255,8'd127},
    {8'd0,8'd255,8'd191},
    {8'd0,8'd255,8'd255}, {8'd0,8'd232,8'd255}, {8'd0,8'd209,8'd255},
    {8'd0,8'd186,8'd255}, {8'd0,8'd163,8'd255}, {8'd0,8'd140,8'd255},
    {8'd0,8'd116,8'd255}, {8'd0,8'd93,8'd255},  {8'd0,8'd70,8'd255},
    {8'd0,8'd47,8'd255},  {8'd0,8'd24,8'd255},
    {8'd0,8'd0,8'd255},   {8'd19,8'd0,8'd255},  {8'd39,8'd0,8'd255},
    {8'd58,8'd0,8'd255},  {8'd78,8'd0,8'd255},  {8'd98,8'd0,8'd255},
    {8'd117,8'd0,8'd255}, {8'd137,8'd0,8'd255}, {8'd156,8'd0,8'd255},
    {8'd176,8'd0,8'd255}, {8'd196,8'd0,8'd255}, {8'd215,8'd0,8'd255},
    {8'd235,8'd0,8'd255},
    {8'd255,8'd0,8'd255}, {8'd255,8'd0,8'd213}, {8'd255,8'd0,8'd170},
    {8'd255,8'd0,8'd128}, {8'd255,8'd0,8'd85},  {8'd255,8'd0,8'd43}
  };

endpackage

### src/flow_vector_color_wheel.sv
// Flow vector color wheel coder: turns a Q8.8 flow vector into a BGR pixel.
// Single module pipeline; depends on fvcw_pkg for types and tables.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   flow_x, flow_y, flow_valid
//   output   out_valid / out_ready blue, green, red
//   config   cfg_we                cfg_data (max_radius, Q8.8)
//
// One transaction enters per cycle while the pipeline is not held; the pipeline depth
// is set by the 32-step square root and the 17-step divider chain.
// Reset clears all pipeline valid bits and loads max_radius with 10.0.
// A one-entry skid buffer behind the output register lets the pipeline take one
// more transaction while a result waits; when it fills, the whole pipeline holds.
module flow_vector_color_wheel
  import fvcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] flow_x,
  input  logic signed [15:0] flow_y,
  input  logic               flow_valid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         blue,
  output logic [7:0]         green,
  output logic [7:0]         red,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);

  logic [15:0]           max_radius;
  item_t                 st [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld;
  logic                  en;
  rgb_t                  out_px;
  rgb_t                  skid_px;
  logic                  skid_valid;
  logic                  out_free;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_radius <= MAX_RADIUS_RESET;
    end else if (cfg_we) begin
      max_radius <= cfg_data;
    end
  end

  // The pipeline advances whenever the skid buffer is empty.
  assign en       = !skid_valid;
  assign in_ready = en;

  // Input stage: capture the vector and the radius in force.
  always_ff @(posedge clk) begin
    if (en) begin
      st[0]      <= '0;
      st[0].fv   <= flow_valid;
      st[0].x    <= flow_x;
      st[0].y    <= flow_y;
      st[0].m    <= (max_radius == 16'd0) ? 16'd1 : max_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  // Remaining stages: each does its share of the work on the item it holds.
  for (genvar g = 1; g < NUM_STAGES; g++) begin : g_stage
    localparam bit DO_CORDIC = (g >= CORDIC_FIRST) && (g < CORDIC_FIRST + CORDIC_STEPS);
    localparam bit DO_SQRT   = (g >= SQRT_FIRST) && (g < SQRT_FIRST + SQRT_STEPS);
    localparam bit DO_DIV    = (g >= DIV_FIRST) && (g < DIV_FIRST + DIV_STEPS);
    localparam int CI = DO_CORDIC ? g - CORDIC_FIRST : 0;
    localparam int SI = DO_SQRT ? g - SQRT_FIRST : 0;
    localparam int DJ = DO_DIV ? g - DIV_FIRST : 0;

    item_t n;

    always_comb begin
      item_t              a;
      logic signed [31:0] px2;
      logic signed [31:0] py2;
      logic signed [33:0] sx;
      logic signed [33:0] sy;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [21:0] da;
      logic [63:0]        rad;
      logic [35:0]        r36;
      logic [35:0]        t36;
      logic [16:0]        rin;
      logic [17:0]        r18;
      logic [19:0]        ang;
      logic [25:0]        tpos;
      logic [5:0]         k1;
      logic [20:0]        frc;
      logic [29:0]        c3;
      logic [44:0]        full;
      logic [44:0]        diff;

      a   = st[g-1];
      px2 = '0; py2 = '0; sx = '0; sy = '0; dx = '0; dy = '0; da = '0;
      rad = '0; r36 = '0; t36 = '0; rin = '0; r18 = '0; ang = '0;
      tpos = '0; k1 = '0; frc = '0; c3 = '0; full = '0; diff = '0;

      // Squares, radius square, angle special cases and CORDIC folding.
      if (g == 1) begin
        px2    = a.x * a.x;
        py2    = a.y * a.y;
        a.x2   = px2[30:0];
        a.y2   = py2[30:0];
        a.mm   = a.m * a.m;
        a.srem = '0;
        a.root = '0;
        a.spec = (a.y == 16'sd0) || (a.x == 16'sd0);
        if (a.y == 16'sd0) begin
          a.sang = (a.x < 16'sd0) ? 20'h80000 : 20'h00000;
        end else begin
          a.sang = (a.y > 16'sd0) ? 20'h40000 : 20'hC0000;
        end
        sx = 34'(a.x);
        sy = 34'(a.y);
        if (a.x < 16'sd0) begin
          a.cx = (-sx) <<< 12;
          a.cy = (-sy) <<< 12;
          a.cz = 22'sh80000;
        end else begin
          a.cx = sx <<< 12;
          a.cy = sy <<< 12;
          a.cz = '0;
        end
      end

      if (g == ST_SQ) begin
        a.sq = 32'(a.x2) + 32'(a.y2);
      end

      if (g == ST_CMP) begin
        a.in_circle = (a.sq <= a.mm);
      end

      // One CORDIC vectoring step.
      if (DO_CORDIC) begin
        dx = a.cy >>> CI;
        dy = a.cx >>> CI;
        da = 22'(ATAN_TURNS[CI]);
        if (a.cy > 34'sd0) begin
          a.cx = a.cx + dx;
          a.cy = a.cy - dy;
          a.cz = a.cz + da;
        end else begin
          a.cx = a.cx - dx;
          a.cy = a.cy + dy;
          a.cz = a.cz - da;
        end
      end

      // One digit of the square root of sq * 2^32.
      if (DO_SQRT) begin
        rad = {a.sq, 32'd0};
        r36 = {a.srem, rad[63-2*SI -: 2]};
        t36 = {2'b00, a.root, 2'b01};
        if (r36 >= t36) begin
          r36    = r36 - t36;
          a.srem = r36[33:0];
          a.root = {a.root[30:0], 1'b1};
        end else begin
          a.srem = r36[33:0];
          a.root = {a.root[30:0], 1'b0};
        end
      end

      // Wheel position from the angle in turns.
      if (g == ST_POS) begin
        ang  = a.spec ? a.sang : a.cz[19:0];
        tpos = 26'(ang) * 26'd54;
        a.k0 = tpos[25:20];
        a.fr = tpos[19:0];
      end

      if (g == ST_LUT) begin
        k1   = (a.k0 == 6'(WHEEL_ENTRIES - 1)) ? 6'd0 : a.k0 + 6'd1;
        a.w0 = WHEEL[a.k0];
        a.w1 = WHEEL[k1];
      end

      // Linear blend between the two neighboring wheel entries.
      if (g == ST_MIX) begin
        frc = 21'h100000 - 21'(a.fr);
        for (int ch = 0; ch < 3; ch++) begin
          a.c[ch] = 28'(frc) * 28'(a.w0[ch]) + 28'(a.fr) * 28'(a.w1[ch]);
        end
      end

      // Distance to white, and the color dimmed to three quarters.
      if (g == ST_SAT) begin
        for (int ch = 0; ch < 3; ch++) begin
          a.d[ch]  = 28'(255 << TURN_BITS) - a.c[ch];
          c3       = 30'(a.c[ch]) * 30'd3;
          a.vo[ch] = c3[29:22];
        end
      end

      // One quotient bit of root / m.
      if (DO_DIV) begin
        rin = (DJ == 0) ? {2'b00, a.root[31:17]} : a.drem;
        r18 = {rin, a.root[16-DJ]};
        if (r18 >= {2'b00, a.m}) begin
          r18    = r18 - {2'b00, a.m};
          a.drem = r18[16:0];
          a.quot = {a.quot[15:0], 1'b1};
        end else begin
          a.drem = r18[16:0];
          a.quot = {a.quot[15:0], 1'b0};
        end
      end

      if (g == ST_PROD) begin
        for (int ch = 0; ch < 3; ch++) begin
          a.prod[ch] = 45'(a.quot) * 45'(a.d[ch]);
        end
      end

      // Final channel select.
      if (g == ST_OUT) begin
        full = 45'd255 << 36;
        for (int ch = 0; ch < 3; ch++) begin
          diff = full - a.prod[ch];
          if (!a.fv) begin
            a.px[ch] = 8'd0;
          end else if (a.in_circle) begin
            a.px[ch] = diff[43:36];
          end else begin
            a.px[ch] = a.vo[ch];
          end
        end
      end

      n = a;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[g] <= n;
      end
    end
  end

  // Output register with a one-entry skid buffer.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= vld[NUM_STAGES-1];
    end else if (vld[NUM_STAGES-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_px <= skid_px;
      end
    end else if (out_free) begin
      out_px <= st[NUM_STAGES-1].px;
    end else begin
      skid_px <= st[NUM_STAGES-1].px;
    end
  end

  assign blue  = out_px[0];
  assign green = out_px[1];
  assign red   = out_px[2];

`ifndef NO_ASSERTIONS
  // The skid buffer only fills behind a result that is waiting.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid buffer holds a transaction while output is empty");

  // The skid buffer only fills when the output was stalled.
  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid buffer filled without an output stall");

  // A held pipeline keeps its valid bits.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits changed during a stall");
`endif

endmodule
